// File: rtl/core/tau_pkg.sv
`timescale 1ns / 1ps
package tau_pkg;
    // Default coordinate width, two's complement with eight fraction bits.
    localparam int COORD_WIDTH = 16;
    // One lane for each altitude: A to BC, B to CA, C to AB.
    localparam int NUM_LANES = 3;
    // Front-end pipeline depth before the root cells.
    localparam int FRONT_STAGES = 5;
endpackage

// File: rtl/core/tau_if.sv
`timescale 1ns / 1ps
interface tau_in_if #(parameter int W = 16);
    logic valid;
    logic ready;
    logic signed [W-1:0] ax, ay, az;
    logic signed [W-1:0] bx, by_coord, bz;
    logic signed [W-1:0] cx, cy, cz;
    modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, input ready);
    modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, output ready);
endinterface

interface tau_out_if #(parameter int W = 16);
    logic valid;
    logic ready;
    logic [W:0] height_a, height_b, height_c;
    logic       degenerate;
    modport source (output valid, height_a, height_b, height_c, degenerate, input ready);
    modport sink (input valid, height_a, height_b, height_c, degenerate, output ready);
endinterface

// File: rtl/core/triangle_altitude_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Transfer payload
// i_tri     in         vertices ax..cz, COORD_WIDTH bits signed each
// o_alt     out        height_a/b/c (COORD_WIDTH+1 bits), degenerate
//
// One triangle per cycle is accepted while o_alt does not stall; a result passes
// through the five front-end stages and then one root cell per result bit.
// Reset (i_rst_n low at a clock edge) clears only the valid bits.
// A stall at o_alt freezes the whole pipeline; i_tri.ready follows from
// o_alt.ready or an empty last stage, so nothing is lost or repeated.
module triangle_altitude_unit #(
    parameter int COORD_WIDTH = tau_pkg::COORD_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tau_in_if.sink    i_tri,
    tau_out_if.source o_alt
);
    import tau_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int EW  = W + 1;
    localparam int KW  = 2 * EW + 1;
    // Squared cross magnitude and squared edge lengths.
    localparam int CW  = 2 * KW + 2;
    localparam int E2W = 2 * EW + 2;
    // Result bits searched, one root cell each, most significant first.
    localparam int HB  = W + 2;
    // Remainder and cost width: covers t*t*E and the squared cross term.
    localparam int SW  = ((CW > E2W + 2 * HB) ? CW : E2W + 2 * HB) + 1;

    logic                  w_en;
    logic signed [W-1:0]   w_coord [9];
    logic                  w_front_valid;
    logic [CW-1:0]         w_c2;
    logic [NUM_LANES-1:0][E2W-1:0] w_e2;
    logic [NUM_LANES-1:0]          w_zero;

    // Chain links: index HB feeds the first cell, index 0 leaves the last.
    logic                          w_vld  [HB+1];
    logic [NUM_LANES-1:0][SW-1:0]  w_rem  [HB+1];
    logic [NUM_LANES-1:0][SW-1:0]  w_q    [HB+1];
    logic [NUM_LANES-1:0][E2W-1:0] w_e2c  [HB+1];
    logic [NUM_LANES-1:0][HB-1:0]  w_t    [HB+1];
    logic [NUM_LANES-1:0]          w_zc   [HB+1];
    logic [W:0]                    w_height [NUM_LANES];

    // The pipeline advances whenever the last stage is empty or drained.
    assign w_en        = o_alt.ready || !o_alt.valid;
    assign i_tri.ready = w_en;

    assign w_coord[0] = i_tri.ax;
    assign w_coord[1] = i_tri.ay;
    assign w_coord[2] = i_tri.az;
    assign w_coord[3] = i_tri.bx;
    assign w_coord[4] = i_tri.by_coord;
    assign w_coord[5] = i_tri.bz;
    assign w_coord[6] = i_tri.cx;
    assign w_coord[7] = i_tri.cy;
    assign w_coord[8] = i_tri.cz;

    tau_front #(.W(W), .CW(CW), .E2W(E2W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_tri.valid),
        .i_coord (w_coord),
        .o_valid (w_front_valid),
        .o_c2    (w_c2),
        .o_e2    (w_e2),
        .o_zero  (w_zero)
    );

    // Each lane starts with the full squared cross magnitude as remainder.
    always_comb begin
        w_vld[HB] = w_front_valid;
        w_e2c[HB] = w_e2;
        w_zc[HB]  = w_zero;
        for (int l = 0; l < NUM_LANES; l++) begin
            w_rem[HB][l] = SW'(w_c2);
            w_q[HB][l]   = '0;
            w_t[HB][l]   = '0;
        end
    end

    for (genvar b = HB - 1; b >= 0; b--) begin : g_cell
        tau_root_cell #(.BIT(b), .HB(HB), .E2W(E2W), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[b+1]),
            .i_rem   (w_rem[b+1]),
            .i_q     (w_q[b+1]),
            .i_e2    (w_e2c[b+1]),
            .i_t     (w_t[b+1]),
            .i_zero  (w_zc[b+1]),
            .o_valid (w_vld[b]),
            .o_rem   (w_rem[b]),
            .o_q     (w_q[b]),
            .o_e2    (w_e2c[b]),
            .o_t     (w_t[b]),
            .o_zero  (w_zc[b])
        );
    end

    // A zero-length edge forces its height to zero; large roots saturate.
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (w_zc[0][l]) begin
                w_height[l] = '0;
            end else if (w_t[0][l][HB-1]) begin
                w_height[l] = '1;
            end else begin
                w_height[l] = w_t[0][l][W:0];
            end
        end
    end

    assign o_alt.valid      = w_vld[0];
    assign o_alt.height_a   = w_height[0];
    assign o_alt.height_b   = w_height[1];
    assign o_alt.height_c   = w_height[2];
    assign o_alt.degenerate = |w_zc[0];
endmodule

// File: rtl/core/tau_front.sv
`timescale 1ns / 1ps
module tau_front #(
    parameter int W   = 16,
    parameter int CW  = 72,
    parameter int E2W = 36
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [W-1:0]   i_coord [9],
    output logic                  o_valid,
    output logic [CW-1:0]         o_c2,
    output logic [tau_pkg::NUM_LANES-1:0][E2W-1:0] o_e2,
    output logic [tau_pkg::NUM_LANES-1:0]          o_zero
);
    import tau_pkg::*;

    localparam int EW = W + 1;
    localparam int PW = 2 * EW;
    localparam int KW = PW + 1;
    localparam int MW = 2 * KW;

    logic [FRONT_STAGES-1:0] r_vld;

    // Stage 1: edges, lane order BC, CA, AB, each as x, y, z.
    logic signed [EW-1:0] r_edge [NUM_LANES][3];
    // Stage 2: cross-product partial products and squared edge components.
    logic signed [PW-1:0] r_prod [6];
    logic [PW-1:0]        r_sq [NUM_LANES][3];
    // Stage 3: cross-product components and squared edge lengths.
    logic signed [KW-1:0] r_k [3];
    logic [E2W-1:0]       r_e2_s3 [NUM_LANES];
    // Stage 4: squared cross components.
    logic [MW-1:0]        r_kk [3];
    logic [E2W-1:0]       r_e2_s4 [NUM_LANES];
    // Stage 5: squared cross magnitude.
    logic [CW-1:0]        r_c2;
    logic [NUM_LANES-1:0][E2W-1:0] r_e2;
    logic [NUM_LANES-1:0]          r_zero;

    logic [KW-1:0] n_kmag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_kmag[i] = r_k[i][KW-1] ? KW'(-r_k[i]) : KW'(r_k[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[FRONT_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                // BC = C - B, CA = A - C, AB = B - A.
                r_edge[0][a] <= EW'(i_coord[6+a]) - EW'(i_coord[3+a]);
                r_edge[1][a] <= EW'(i_coord[a])   - EW'(i_coord[6+a]);
                r_edge[2][a] <= EW'(i_coord[3+a]) - EW'(i_coord[a]);
            end

            r_prod[0] <= r_edge[0][1] * r_edge[2][2];
            r_prod[1] <= r_edge[0][2] * r_edge[2][1];
            r_prod[2] <= r_edge[0][2] * r_edge[2][0];
            r_prod[3] <= r_edge[0][0] * r_edge[2][2];
            r_prod[4] <= r_edge[0][0] * r_edge[2][1];
            r_prod[5] <= r_edge[0][1] * r_edge[2][0];
            for (int l = 0; l < NUM_LANES; l++) begin
                for (int a = 0; a < 3; a++) begin
                    r_sq[l][a] <= PW'(r_edge[l][a] * r_edge[l][a]);
                end
            end

            r_k[0] <= KW'(r_prod[0]) - KW'(r_prod[1]);
            r_k[1] <= KW'(r_prod[2]) - KW'(r_prod[3]);
            r_k[2] <= KW'(r_prod[4]) - KW'(r_prod[5]);
            for (int l = 0; l < NUM_LANES; l++) begin
                r_e2_s3[l] <= E2W'(r_sq[l][0]) + E2W'(r_sq[l][1]) + E2W'(r_sq[l][2]);
            end

            for (int i = 0; i < 3; i++) begin
                r_kk[i] <= n_kmag[i] * n_kmag[i];
            end
            r_e2_s4 <= r_e2_s3;

            r_c2 <= CW'(r_kk[0]) + CW'(r_kk[1]) + CW'(r_kk[2]);
            for (int l = 0; l < NUM_LANES; l++) begin
                r_e2[l]   <= r_e2_s4[l];
                r_zero[l] <= (r_e2_s4[l] == '0);
            end
        end
    end

    assign o_valid = r_vld[FRONT_STAGES-1];
    assign o_c2    = r_c2;
    assign o_e2    = r_e2;
    assign o_zero  = r_zero;
endmodule

// File: rtl/core/tau_root_cell.sv
`timescale 1ns / 1ps
module tau_root_cell #(
    parameter int BIT = 0,
    parameter int HB  = 18,
    parameter int E2W = 36,
    parameter int SW  = 73
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_valid,
    input  logic [tau_pkg::NUM_LANES-1:0][SW-1:0]    i_rem,
    input  logic [tau_pkg::NUM_LANES-1:0][SW-1:0]    i_q,
    input  logic [tau_pkg::NUM_LANES-1:0][E2W-1:0]   i_e2,
    input  logic [tau_pkg::NUM_LANES-1:0][HB-1:0]    i_t,
    input  logic [tau_pkg::NUM_LANES-1:0]            i_zero,
    output logic                                     o_valid,
    output logic [tau_pkg::NUM_LANES-1:0][SW-1:0]    o_rem,
    output logic [tau_pkg::NUM_LANES-1:0][SW-1:0]    o_q,
    output logic [tau_pkg::NUM_LANES-1:0][E2W-1:0]   o_e2,
    output logic [tau_pkg::NUM_LANES-1:0][HB-1:0]    o_t,
    output logic [tau_pkg::NUM_LANES-1:0]            o_zero
);
    import tau_pkg::*;

    // With q = t*E and rem = C - t*t*E, setting this bit costs
    // (q << (BIT+1)) + (E << 2*BIT) from the remainder.
    logic                                r_valid;
    logic [NUM_LANES-1:0][SW-1:0]        r_rem, r_q;
    logic [NUM_LANES-1:0][E2W-1:0]       r_e2;
    logic [NUM_LANES-1:0][HB-1:0]        r_t;
    logic [NUM_LANES-1:0]                r_zero;
    logic [NUM_LANES-1:0][SW-1:0]        n_cost;
    logic [NUM_LANES-1:0]                n_take;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            n_cost[l] = (i_q[l] << (BIT + 1)) + (SW'(i_e2[l]) << (2 * BIT));
            n_take[l] = (n_cost[l] <= i_rem[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_e2[l]   <= i_e2[l];
                r_zero[l] <= i_zero[l];
                if (n_take[l]) begin
                    r_rem[l] <= i_rem[l] - n_cost[l];
                    r_q[l]   <= i_q[l] + (SW'(i_e2[l]) << BIT);
                    r_t[l]   <= i_t[l] | (HB'(1) << BIT);
                end else begin
                    r_rem[l] <= i_rem[l];
                    r_q[l]   <= i_q[l];
                    r_t[l]   <= i_t[l];
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign o_e2    = r_e2;
    assign o_t     = r_t;
    assign o_zero  = r_zero;
endmodule
